// File: hw/rtl/vc_input_port_relay_core_macros.svh
// assertion macros shared by the relay core checkers
`ifndef VC_INPUT_PORT_RELAY_CORE_MACROS_SVH
`define VC_INPUT_PORT_RELAY_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define VCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define VCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vcr_pkg.sv
// types and constants of the virtual channel input port relay
package vcr_pkg;

    localparam int PAYLOAD_W   = 32;
    localparam int HOPS_W      = 8;
    localparam int VC_FIELD_W  = 3;
    localparam int CREDIT_W    = 3;
    localparam int DOWN_CRED_W = 8;
    localparam int NUMVC_W     = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 48;

    localparam logic [NUMVC_W-1:0] NUMVC_RESET = 4'd4;
    localparam logic [HOPS_W-1:0]  HOPS_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        CMD_RECEIVE = 2'd0,
        CMD_POP     = 2'd1,
        CMD_SKIP    = 2'd2,
        CMD_SEND    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_BUSY     = 2'd1,
        STAT_BAD_VC   = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } state_t;

    typedef enum logic {
        CFG_NUM_VCS = 1'b0,
        CFG_PORT_ID = 1'b1
    } cfg_idx_t;

endpackage

// File: hw/rtl/vc_input_port_relay_core.sv
// virtual channel input port relay: per-channel flit fifos in one slot memory
//
//  channel   direction  handshake            contents
//  s_        in         s_tvalid / s_tready  command (tuser), flit and link levels (tdata)
//  m_        out        m_tvalid / m_tready  status (tuser), flit, levels, credit (tdata)
//  cfg_      in         cfg_valid/cfg_ready  register index, write data
//
//  receive, skip and send pass through capture and execute
//  pop adds a read state after execute for the registered read of the slot memory
//  one item in work at a time; the next item is taken while a result waits on m_
//  a stalled m_ side holds the item in execute (a pop in its read state) until the
//  output register frees up
//  aresetn is synchronous; no clearing pass, the slot memory is read only where written
//  writing num_vcs empties every fifo at once through the fill counts and head pointers
module vc_input_port_relay_core #(
    parameter int MAX_VCS   = 8,
    parameter int BUF_DEPTH = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // req_level, flit_vc, flit_payload, flit_hops, ack_level, down_free_slots, zero pad
    input  logic [vcr_pkg::S_TDATA_W-1:0]    s_tdata,
    // command
    input  logic [1:0]                       s_tuser,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_vc, out_payload, out_hops, rx_ack_level, tx_req_level, credit_free
    output logic [vcr_pkg::M_TDATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                       m_tuser,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [0:0]                       cfg_index,
    input  logic [vcr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int VC_W      = (MAX_VCS > 1) ? $clog2(MAX_VCS) : 1;
    localparam int NV_W      = $clog2(MAX_VCS + 1);
    localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int MEM_DEPTH = MAX_VCS * BUF_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SLOT_W    = vcr_pkg::PAYLOAD_W + vcr_pkg::HOPS_W;

    // fsm
    vcr_pkg::state_t state_reg, state_next;

    // captured item
    vcr_pkg::cmd_t                       cmd_reg;
    logic                                req_reg;
    logic [vcr_pkg::VC_FIELD_W-1:0]      vc_reg;
    logic [vcr_pkg::PAYLOAD_W-1:0]       pay_reg;
    logic [vcr_pkg::HOPS_W-1:0]          hops_reg;
    logic                                ack_reg;
    logic [vcr_pkg::DOWN_CRED_W-1:0]     dcred_reg;

    // port state
    logic [vcr_pkg::NUMVC_W-1:0]         num_vcs_reg;
    logic [VC_W-1:0]                     rr_reg;
    logic                                rx_level_reg;
    logic                                tx_level_reg;
    logic [CNT_W-1:0]                    fill_reg [MAX_VCS];
    logic [PTR_W-1:0]                    head_reg [MAX_VCS];

    // slot memory and its read side
    logic [SLOT_W-1:0]                   slot_mem [MEM_DEPTH];
    logic [SLOT_W-1:0]                   rd_data_reg;
    logic [VC_W-1:0]                     pop_vc_reg;
    logic [vcr_pkg::CREDIT_W-1:0]        pop_free_reg;

    // output register
    logic                                m_tvalid_reg;
    vcr_pkg::status_t                    out_status_reg, out_status_next;
    logic [vcr_pkg::VC_FIELD_W-1:0]      out_vc_reg, out_vc_next;
    logic [vcr_pkg::PAYLOAD_W-1:0]       out_pay_reg, out_pay_next;
    logic [vcr_pkg::HOPS_W-1:0]          out_hops_reg, out_hops_next;
    logic                                out_rx_reg;
    logic                                out_tx_reg;
    logic [vcr_pkg::CREDIT_W-1:0]        out_credit_reg, out_credit_next;

    // control from the fsm
    logic s_accept, cfg_accept, out_free, ld_out;
    logic push_en, pop_en, skip_en, rx_tog, tx_tog;

    // datapath
    logic [NV_W-1:0]          n_active;
    logic [VC_W-1:0]          vc_idx;
    logic [CNT_W-1:0]         rx_fill;
    logic [PTR_W-1:0]         rx_head;
    logic [SUM_W-1:0]         rx_sum;
    logic [PTR_W-1:0]         rx_slot;
    logic [ADDR_W-1:0]        wr_addr;
    logic [vcr_pkg::HOPS_W-1:0] hops_inc;
    logic                     rx_bad_vc, rx_full;
    logic [vcr_pkg::CREDIT_W-1:0] rx_free;

    logic                     found_hi, found_lo, pop_found;
    logic [VC_W-1:0]          pick_hi, pick_lo, pop_vc;
    logic [CNT_W-1:0]         pop_fill;
    logic [PTR_W-1:0]         pop_head, pop_head_next;
    logic [ADDR_W-1:0]        rd_addr;
    logic [vcr_pkg::CREDIT_W-1:0] pop_free;

    logic [VC_W-1:0]          rr_next;
    logic                     send_ok;

    assign s_tready   = (state_reg == vcr_pkg::ST_IDLE);
    assign cfg_ready  = (state_reg == vcr_pkg::ST_IDLE);
    assign s_accept   = s_tvalid & s_tready;
    assign cfg_accept = cfg_valid & cfg_ready;
    assign out_free   = !m_tvalid_reg || m_tready;

    // channels in use: zero acts as one, above the build limit clamps
    always_comb begin
        if (num_vcs_reg == '0) begin
            n_active = NV_W'(1);
        end else if (int'(num_vcs_reg) > MAX_VCS) begin
            n_active = NV_W'(MAX_VCS);
        end else begin
            n_active = NV_W'(num_vcs_reg);
        end
    end

    // receive path: tail slot is head plus fill, wrapped once
    assign vc_idx    = VC_W'(vc_reg);
    assign rx_bad_vc = int'(vc_reg) >= int'(n_active);
    assign rx_fill   = fill_reg[vc_idx];
    assign rx_head   = head_reg[vc_idx];
    assign rx_full   = (rx_fill == CNT_W'(BUF_DEPTH));
    assign rx_sum    = SUM_W'(rx_head) + SUM_W'(rx_fill);
    assign rx_slot   = (rx_sum >= SUM_W'(BUF_DEPTH)) ? PTR_W'(rx_sum - SUM_W'(BUF_DEPTH))
                                                      : PTR_W'(rx_sum);
    assign wr_addr   = ADDR_W'(int'(vc_idx) * BUF_DEPTH + int'(rx_slot));
    assign hops_inc  = (hops_reg == vcr_pkg::HOPS_MAX) ? vcr_pkg::HOPS_MAX
                                                       : hops_reg + 1'b1;
    assign rx_free   = vcr_pkg::CREDIT_W'(BUF_DEPTH - int'(rx_fill) - 1);

    // pop path: round robin pick, first non-empty channel at or above the pointer,
    // else the lowest non-empty channel below it
    always_comb begin
        found_hi = 1'b0;
        found_lo = 1'b0;
        pick_hi  = '0;
        pick_lo  = '0;
        for (int c = MAX_VCS - 1; c >= 0; c--) begin
            if (c < int'(n_active) && fill_reg[c] != '0) begin
                found_lo = 1'b1;
                pick_lo  = VC_W'(c);
                if (c >= int'(rr_reg)) begin
                    found_hi = 1'b1;
                    pick_hi  = VC_W'(c);
                end
            end
        end
    end

    assign pop_found     = found_hi | found_lo;
    assign pop_vc        = found_hi ? pick_hi : pick_lo;
    assign pop_fill      = fill_reg[pop_vc];
    assign pop_head      = head_reg[pop_vc];
    assign pop_head_next = (pop_head == PTR_W'(BUF_DEPTH - 1)) ? '0 : pop_head + 1'b1;
    assign rd_addr       = ADDR_W'(int'(pop_vc) * BUF_DEPTH + int'(pop_head));
    assign pop_free      = vcr_pkg::CREDIT_W'(BUF_DEPTH - int'(pop_fill) + 1);

    // skip wraps inside the channels in use
    assign rr_next = (int'(rr_reg) + 1 == int'(n_active)) ? '0 : rr_reg + 1'b1;

    // send needs a matching ack level and downstream credit
    assign send_ok = (tx_level_reg == ack_reg) && (dcred_reg != '0);

    // fsm: next state, commit enables and result fields
    always_comb begin
        state_next      = state_reg;
        ld_out          = 1'b0;
        push_en         = 1'b0;
        pop_en          = 1'b0;
        skip_en         = 1'b0;
        rx_tog          = 1'b0;
        tx_tog          = 1'b0;
        out_status_next = vcr_pkg::STAT_BUSY;
        out_vc_next     = '0;
        out_pay_next    = '0;
        out_hops_next   = '0;
        out_credit_next = '0;
        unique case (state_reg)
            vcr_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = vcr_pkg::ST_EXEC;
                end
            end
            vcr_pkg::ST_EXEC: begin
                unique case (cmd_reg)
                    vcr_pkg::CMD_RECEIVE: begin
                        if (out_free) begin
                            ld_out     = 1'b1;
                            state_next = vcr_pkg::ST_IDLE;
                            if (req_reg != rx_level_reg) begin
                                out_vc_next = vc_reg;
                                if (rx_bad_vc) begin
                                    out_status_next = vcr_pkg::STAT_BAD_VC;
                                end else if (rx_full) begin
                                    out_status_next = vcr_pkg::STAT_OVERFLOW;
                                end else begin
                                    out_status_next = vcr_pkg::STAT_DONE;
                                    out_hops_next   = hops_inc;
                                    out_credit_next = rx_free;
                                    push_en         = 1'b1;
                                    rx_tog          = 1'b1;
                                end
                            end
                        end
                    end
                    vcr_pkg::CMD_POP: begin
                        if (pop_found) begin
                            // state moves now, the flit comes out of memory next cycle
                            pop_en     = 1'b1;
                            state_next = vcr_pkg::ST_READ;
                        end else if (out_free) begin
                            ld_out     = 1'b1;
                            state_next = vcr_pkg::ST_IDLE;
                        end
                    end
                    vcr_pkg::CMD_SKIP: begin
                        if (out_free) begin
                            ld_out          = 1'b1;
                            skip_en         = 1'b1;
                            out_status_next = vcr_pkg::STAT_DONE;
                            state_next      = vcr_pkg::ST_IDLE;
                        end
                    end
                    vcr_pkg::CMD_SEND: begin
                        if (out_free) begin
                            ld_out     = 1'b1;
                            state_next = vcr_pkg::ST_IDLE;
                            if (send_ok) begin
                                out_status_next = vcr_pkg::STAT_DONE;
                                out_vc_next     = vc_reg;
                                out_pay_next    = pay_reg;
                                out_hops_next   = hops_reg;
                                tx_tog          = 1'b1;
                            end
                        end
                    end
                endcase
            end
            vcr_pkg::ST_READ: begin
                if (out_free) begin
                    ld_out          = 1'b1;
                    out_status_next = vcr_pkg::STAT_DONE;
                    out_vc_next     = vcr_pkg::VC_FIELD_W'(pop_vc_reg);
                    out_pay_next    = rd_data_reg[vcr_pkg::PAYLOAD_W-1:0];
                    out_hops_next   = rd_data_reg[SLOT_W-1:vcr_pkg::PAYLOAD_W];
                    out_credit_next = pop_free_reg;
                    state_next      = vcr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vcr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= vcr_pkg::cmd_t'(s_tuser);
            req_reg   <= s_tdata[0];
            vc_reg    <= s_tdata[3:1];
            pay_reg   <= s_tdata[35:4];
            hops_reg  <= s_tdata[43:36];
            ack_reg   <= s_tdata[44];
            dcred_reg <= s_tdata[52:45];
        end
    end

    // fifo bookkeeping, levels, pointer and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vcs_reg  <= vcr_pkg::NUMVC_RESET;
            rr_reg       <= '0;
            rx_level_reg <= 1'b0;
            tx_level_reg <= 1'b0;
            for (int c = 0; c < MAX_VCS; c++) begin
                fill_reg[c] <= '0;
                head_reg[c] <= '0;
            end
        end else begin
            if (cfg_accept) begin
                unique case (vcr_pkg::cfg_idx_t'(cfg_index))
                    vcr_pkg::CFG_NUM_VCS: begin
                        // new channel count empties every fifo
                        num_vcs_reg <= cfg_data[vcr_pkg::NUMVC_W-1:0];
                        rr_reg      <= '0;
                        for (int c = 0; c < MAX_VCS; c++) begin
                            fill_reg[c] <= '0;
                            head_reg[c] <= '0;
                        end
                    end
                    vcr_pkg::CFG_PORT_ID: begin
                        // port id is not stored and leaves no trace in results
                    end
                endcase
            end
            if (push_en) begin
                fill_reg[vc_idx] <= rx_fill + 1'b1;
            end
            if (pop_en) begin
                fill_reg[pop_vc] <= pop_fill - 1'b1;
                head_reg[pop_vc] <= pop_head_next;
            end
            if (skip_en) begin
                rr_reg <= rr_next;
            end
            if (rx_tog) begin
                rx_level_reg <= ~rx_level_reg;
            end
            if (tx_tog) begin
                tx_level_reg <= ~tx_level_reg;
            end
        end
    end

    // slot memory: one write port for receive, one registered read port for pop
    always_ff @(posedge aclk) begin
        if (push_en) begin
            slot_mem[wr_addr] <= {hops_inc, pay_reg};
        end
        if (pop_en) begin
            rd_data_reg  <= slot_mem[rd_addr];
            pop_vc_reg   <= pop_vc;
            pop_free_reg <= pop_free;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ld_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            out_status_reg <= out_status_next;
            out_vc_reg     <= out_vc_next;
            out_pay_reg    <= out_pay_next;
            out_hops_reg   <= out_hops_next;
            out_rx_reg     <= rx_level_reg ^ rx_tog;
            out_tx_reg     <= tx_level_reg ^ tx_tog;
            out_credit_reg <= out_credit_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_credit_reg, out_tx_reg, out_rx_reg,
                       out_hops_reg, out_pay_reg, out_vc_reg};

endmodule

// File: hw/rtl/vcr_checker.sv
// port-level checks of the relay core, bound to the top level
`include "vc_input_port_relay_core_macros.svh"

module vcr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [vcr_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [1:0]                       m_tuser
);

    // a result held back keeps its contents
    `VCR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // one item in work: input closes right after an item is taken
    `VCR_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken while one is in work")

    // a dropped flit reports only its channel and the link levels
    `VCR_ASSERT_SAME(a_drop_clean, aclk, aresetn, m_tvalid && (m_tuser == vcr_pkg::STAT_BAD_VC || m_tuser == vcr_pkg::STAT_OVERFLOW), m_tdata[42:3] == '0 && m_tdata[47:45] == '0, "dropped flit result carries data")

    // a refused command carries no flit at all
    `VCR_ASSERT_SAME(a_busy_clean, aclk, aresetn, m_tvalid && m_tuser == vcr_pkg::STAT_BUSY, m_tdata[42:0] == '0 && m_tdata[47:45] == '0, "refused command result carries data")

endmodule

bind vc_input_port_relay_core vcr_checker u_vcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/tb_vc_input_port_relay_core.sv
// testbench for the virtual channel input port relay core: random and directed flits checked by a scoreboard
module tb_vc_input_port_relay_core;

    localparam int NUM_VC_SLOTS = 8;
    localparam int FIFO_DEPTH   = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 118;

    // one result item as the block reports it
    typedef struct {
        vcr_pkg::status_t                  st;
        logic [vcr_pkg::VC_FIELD_W-1:0]    vc;
        logic [vcr_pkg::PAYLOAD_W-1:0]     payload;
        logic [vcr_pkg::HOPS_W-1:0]        hops;
        logic                              rx_lvl;
        logic                              tx_lvl;
        logic [vcr_pkg::CREDIT_W-1:0]      credit;
    } relay_result_t;

    // flit fifo model of the port plus the queue of results still owed by the block
    class relay_scoreboard;
        logic [vcr_pkg::PAYLOAD_W-1:0]  slot_payload [NUM_VC_SLOTS*FIFO_DEPTH];
        logic [vcr_pkg::HOPS_W-1:0]     slot_hops [NUM_VC_SLOTS*FIFO_DEPTH];
        logic [1:0]                     head [NUM_VC_SLOTS];
        logic [2:0]                     fill [NUM_VC_SLOTS];
        logic [2:0]                     rr;
        logic                           rx_lvl;
        logic                           tx_lvl;
        logic [vcr_pkg::NUMVC_W-1:0]    num_vcs;
        relay_result_t                  owed_q[$];
        int                             errors;

        function new();
            clear_fifos();
            rx_lvl   = 1'b0;
            tx_lvl   = 1'b0;
            num_vcs  = vcr_pkg::NUMVC_RESET;
            errors   = 0;
        endfunction

        // zero means one channel, anything above the slot count means all of them
        function int active_vcs();
            if (num_vcs == 0) return 1;
            if (num_vcs > NUM_VC_SLOTS) return NUM_VC_SLOTS;
            return int'(num_vcs);
        endfunction

        function void clear_fifos();
            for (int c = 0; c < NUM_VC_SLOTS; c++) begin
                head[c] = '0;
                fill[c] = '0;
            end
            rr = '0;
        endfunction

        // the port id has no effect on any result
        function void write_reg(vcr_pkg::cfg_idx_t idx, logic [vcr_pkg::CFG_DATA_W-1:0] data);
            if (idx == vcr_pkg::CFG_NUM_VCS) begin
                num_vcs = data[vcr_pkg::NUMVC_W-1:0];
                clear_fifos();
            end
        endfunction

        function void note_item(vcr_pkg::cmd_t cmd, logic [vcr_pkg::S_TDATA_W-1:0] d);
            logic                            req;
            logic [vcr_pkg::VC_FIELD_W-1:0]  vc;
            logic [vcr_pkg::PAYLOAD_W-1:0]   payload;
            logic [vcr_pkg::HOPS_W-1:0]      hops;
            logic                            ack;
            logic [vcr_pkg::DOWN_CRED_W-1:0] down_credit;
            relay_result_t                   res;
            int                              n;
            int                              slot;
            int                              start;
            int                              i;
            int                              c;

            req         = d[0];
            vc          = d[3:1];
            payload     = d[35:4];
            hops        = d[43:36];
            ack         = d[44];
            down_credit = d[52:45];
            n           = active_vcs();
            res.st      = vcr_pkg::STAT_BUSY;
            res.vc      = '0;
            res.payload = '0;
            res.hops    = '0;
            res.credit  = '0;

            case (cmd)
                vcr_pkg::CMD_RECEIVE: begin
                    // same level as last time means no new flit on the link
                    if (req != rx_lvl) begin
                        res.vc = vc;
                        if (int'(vc) >= n) begin
                            res.st = vcr_pkg::STAT_BAD_VC;
                        end else if (fill[vc] >= FIFO_DEPTH) begin
                            res.st = vcr_pkg::STAT_OVERFLOW;
                        end else begin
                            slot = int'(vc) * FIFO_DEPTH
                                   + (int'(head[vc]) + int'(fill[vc])) % FIFO_DEPTH;
                            slot_payload[slot] = payload;
                            slot_hops[slot]    = (hops == vcr_pkg::HOPS_MAX) ? vcr_pkg::HOPS_MAX
                                                                             : hops + 8'd1;
                            fill[vc]           = fill[vc] + 3'd1;
                            rx_lvl             = ~rx_lvl;
                            res.st             = vcr_pkg::STAT_DONE;
                            res.hops           = slot_hops[slot];
                            res.credit         = 3'(FIFO_DEPTH - int'(fill[vc]));
                        end
                    end
                end
                vcr_pkg::CMD_POP: begin
                    // round robin search from the pointer, pointer itself stays put
                    start = int'(rr) % n;
                    i = 0;
                    while (i < n && fill[(start + i) % n] == 0) i++;
                    if (i < n) begin
                        c           = (start + i) % n;
                        slot        = c * FIFO_DEPTH + int'(head[c]);
                        res.payload = slot_payload[slot];
                        res.hops    = slot_hops[slot];
                        head[c]     = 2'((int'(head[c]) + 1) % FIFO_DEPTH);
                        fill[c]     = fill[c] - 3'd1;
                        res.vc      = 3'(c);
                        res.credit  = 3'(FIFO_DEPTH - int'(fill[c]));
                        res.st      = vcr_pkg::STAT_DONE;
                    end
                end
                vcr_pkg::CMD_SKIP: begin
                    rr     = 3'((int'(rr) + 1) % n);
                    res.st = vcr_pkg::STAT_DONE;
                end
                default: begin
                    // send needs a matching ack level and some downstream credit
                    if (tx_lvl == ack && down_credit != 0) begin
                        tx_lvl      = ~tx_lvl;
                        res.st      = vcr_pkg::STAT_DONE;
                        res.vc      = vc;
                        res.payload = payload;
                        res.hops    = hops;
                    end
                end
            endcase
            res.rx_lvl = rx_lvl;
            res.tx_lvl = tx_lvl;
            owed_q.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $error("%s: expected %0h, got %0h", field, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [vcr_pkg::M_TDATA_W-1:0] d);
            relay_result_t exp_r;
            if (owed_q.size() == 0) begin
                errors++;
                $error("result item with nothing expected: status %0h data %0h", st, d);
                return;
            end
            exp_r = owed_q.pop_front();
            compare_field("status", 32'(exp_r.st), 32'(st));
            compare_field("out_vc", 32'(exp_r.vc), 32'(d[2:0]));
            compare_field("out_payload", exp_r.payload, d[34:3]);
            compare_field("out_hops", 32'(exp_r.hops), 32'(d[42:35]));
            compare_field("rx_ack_level", 32'(exp_r.rx_lvl), 32'(d[43]));
            compare_field("tx_req_level", 32'(exp_r.tx_lvl), 32'(d[44]));
            compare_field("credit_free", 32'(exp_r.credit), 32'(d[47:45]));
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [vcr_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [vcr_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [1:0]                     m_tuser;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [0:0]                     cfg_index;
    logic [vcr_pkg::CFG_DATA_W-1:0] cfg_data;

    relay_scoreboard sb;
    // sender and receiver each switch between gapped and back-to-back stretches
    bit src_gapless;
    bit sink_gapless;
    // one-shot request for a long receiver stall
    bit hold_request;

    always #6 aclk = ~aclk;

    vc_input_port_relay_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // input side monitor: every accepted item updates the model and queues its result
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_item(vcr_pkg::cmd_t'(s_tuser), s_tdata);
        end
    end

    // output side monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata);
        end
    end

    // offer one item, called and returning at a falling edge
    task automatic drive_item(vcr_pkg::cmd_t cmd, logic req,
                              logic [vcr_pkg::VC_FIELD_W-1:0] vc,
                              logic [vcr_pkg::PAYLOAD_W-1:0] payload,
                              logic [vcr_pkg::HOPS_W-1:0] hops, logic ack,
                              logic [vcr_pkg::DOWN_CRED_W-1:0] down_credit);
        int gap;
        if ($urandom_range(0, 47) == 0) src_gapless = ~src_gapless;
        gap = src_gapless ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, down_credit, ack, hops, payload, vc, req};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // well-formed receive: request level opposite to the port's current ack level
    task automatic receive_flit(logic [vcr_pkg::VC_FIELD_W-1:0] vc,
                                logic [vcr_pkg::PAYLOAD_W-1:0] payload,
                                logic [vcr_pkg::HOPS_W-1:0] hops);
        drive_item(vcr_pkg::CMD_RECEIVE, ~sb.rx_lvl, vc, payload, hops,
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // register writes only with nothing in flight: wait for every owed result, then idle before the write
    task automatic write_reg(vcr_pkg::cfg_idx_t idx, logic [vcr_pkg::CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int count);
        int                              n;
        int                              pick;
        logic [vcr_pkg::VC_FIELD_W-1:0]  vc;
        logic [vcr_pkg::HOPS_W-1:0]      hops;
        logic                            lvl;
        logic [vcr_pkg::DOWN_CRED_W-1:0] down_credit;
        for (int k = 0; k < count; k++) begin
            n    = sb.active_vcs();
            pick = $urandom_range(0, 99);
            // mostly legal channels, now and then any channel at all
            vc   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, n - 1));
            case ($urandom_range(0, 7))
                0:       hops = vcr_pkg::HOPS_MAX;
                1:       hops = vcr_pkg::HOPS_MAX - 8'd1;
                2:       hops = '0;
                default: hops = 8'($urandom_range(0, 255));
            endcase
            if (pick < 45) begin
                // a stale request level now and then
                lvl = ($urandom_range(0, 7) == 0) ? sb.rx_lvl : ~sb.rx_lvl;
                drive_item(vcr_pkg::CMD_RECEIVE, lvl, vc, $urandom, hops,
                           1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else if (pick < 75) begin
                drive_item(vcr_pkg::CMD_POP, 1'($urandom_range(0, 1)),
                           3'($urandom_range(0, 7)), $urandom, hops,
                           1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else if (pick < 83) begin
                drive_item(vcr_pkg::CMD_SKIP, 1'($urandom_range(0, 1)),
                           3'($urandom_range(0, 7)), $urandom, hops,
                           1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else begin
                lvl         = ($urandom_range(0, 5) == 0) ? ~sb.tx_lvl : sb.tx_lvl;
                down_credit = ($urandom_range(0, 5) == 0) ? '0 : 8'($urandom_range(0, 255));
                drive_item(vcr_pkg::CMD_SEND, 1'($urandom_range(0, 1)),
                           3'($urandom_range(0, 7)), $urandom, hops, lvl, down_credit);
            end
        end
    endtask

    // result side: random backpressure with one long stall on request
    initial begin
        int hold;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) sink_gapless = ~sink_gapless;
            if (hold_request) begin
                hold         = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                hold = sink_gapless ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // run limit, far above the slowest correct run
    initial begin
        #4800000;
        $display("[vc_input_port_relay_core] ERROR");
        $finish;
    end

    initial begin
        logic [vcr_pkg::NUMVC_W-1:0] vc_counts [7];
        sb = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = vcr_pkg::CMD_RECEIVE;
        cfg_valid = 1'b0;
        cfg_index = vcr_pkg::CFG_NUM_VCS;
        cfg_data  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset setting of four channels
        drive_item(vcr_pkg::CMD_POP, 1'b0, 3'd0, '0, '0, 1'b0, '0);       // all fifos empty
        drive_item(vcr_pkg::CMD_RECEIVE, sb.rx_lvl, 3'd2, 32'h1234_5678, 8'd9, 1'b1,
                   8'hFF);                                                 // stale level
        receive_flit(3'd0, 32'h0000_0000, 8'd0);
        receive_flit(3'd1, 32'hFFFF_FFFF, vcr_pkg::HOPS_MAX);             // hop count saturates
        receive_flit(3'd7, 32'hA5A5_A5A5, 8'd8);                          // channel out of range
        receive_flit(3'd4, 32'h0F0F_0F0F, 8'd1);                          // first channel past the end
        receive_flit(3'd3, 32'h5A5A_5A5A, vcr_pkg::HOPS_MAX - 8'd1);
        drive_item(vcr_pkg::CMD_SKIP, 1'b1, 3'd7, 32'hFFFF_FFFF, vcr_pkg::HOPS_MAX, 1'b1,
                   8'hFF);
        // pointer at one: pops come out as channel 1, 3, then 0
        repeat (3) drive_item(vcr_pkg::CMD_POP, 1'b1, 3'd7, '0, '0, 1'b1, 8'hFF);
        drive_item(vcr_pkg::CMD_POP, 1'b0, 3'd0, '0, '0, 1'b0, '0);
        // fill channel 2, the fifth flit overflows
        repeat (5) receive_flit(3'd2, $urandom, 8'($urandom_range(0, 255)));
        drive_item(vcr_pkg::CMD_SEND, 1'b0, 3'd5, 32'hDEAD_BEEF, 8'd3, sb.tx_lvl,
                   8'd0);                                                  // no credit
        drive_item(vcr_pkg::CMD_SEND, 1'b0, 3'd5, 32'hDEAD_BEEF, 8'd3, ~sb.tx_lvl,
                   8'hFF);                                                 // ack mismatch
        drive_item(vcr_pkg::CMD_SEND, 1'b1, 3'd7, 32'hFFFF_FFFF, vcr_pkg::HOPS_MAX,
                   sb.tx_lvl, 8'hFF);
        drive_item(vcr_pkg::CMD_SEND, 1'b0, 3'd0, 32'h0000_0000, 8'd0, sb.tx_lvl, 8'd1);
        repeat (3) drive_item(vcr_pkg::CMD_SKIP, 1'b0, 3'd0, '0, '0, 1'b0, '0); // pointer wraps
        drive_item(vcr_pkg::CMD_POP, 1'b0, 3'd0, '0, '0, 1'b0, '0);

        // channel counts: extremes, zero and above the maximum, two middle values, then a random one
        vc_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6, 4'($urandom_range(0, 15))};
        for (int p = 0; p < 7; p++) begin
            // junk in the upper data bits must be ignored for num_vcs
            write_reg(vcr_pkg::CFG_NUM_VCS, {12'($urandom), vc_counts[p]});
            case (p % 3)
                0:       write_reg(vcr_pkg::CFG_PORT_ID, 16'hFFFF);
                1:       write_reg(vcr_pkg::CFG_PORT_ID, 16'h0000);
                default: write_reg(vcr_pkg::CFG_PORT_ID, 16'($urandom_range(0, 65535)));
            endcase
            // long receiver stall with eight channels so the pipeline backs up into the input
            if (p == 1) hold_request = 1'b1;
            random_items(PHASE_ITEMS);
        end
        s_tvalid <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("[vc_input_port_relay_core] OK");
        end else begin
            $display("[vc_input_port_relay_core] ERROR");
        end
        $finish;
    end

endmodule
